// File: rtl/rcd_pkg.sv
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared width constant and stage types of the rounding / ceiling divider.
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int DW = 64;

    typedef struct packed {
        logic          func;
        logic          zero_a;
        logic          zero_b;
        logic [DW-1:0] div;
        logic [DW-1:0] rem;
        logic [DW-1:0] nq;
    } t_stage;

    typedef struct packed {
        logic          zero_a;
        logic          zero_b;
        logic          inc;
        logic [DW-1:0] q;
    } t_fin;

endpackage

// File: rtl/rcd_if.sv
// ----------------------------------------------------------------------------
// rcd_in_if / rcd_out_if
// Valid/ready channels carrying divide requests and quotients.
// ----------------------------------------------------------------------------
interface rcd_in_if;
    import rcd_pkg::*;

    logic          valid;
    logic          ready;
    logic          func;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;

    modport source (output valid, func, dividend, divisor, input ready);
    modport sink   (input valid, func, dividend, divisor, output ready);
endinterface

interface rcd_out_if;
    import rcd_pkg::*;

    logic          valid;
    logic          ready;
    logic [DW-1:0] quotient;
    logic          divide_by_zero;

    modport source (output valid, quotient, divide_by_zero, input ready);
    modport sink   (input valid, quotient, divide_by_zero, output ready);
endinterface

// File: rtl/rounding_ceiling_divider.sv
// ----------------------------------------------------------------------------
// rounding_ceiling_divider
// Pipelined unsigned divider: round-to-nearest (halves up) or ceiling.
//
//   channel | dir | fields
//   i_req   | in  | func, dividend, divisor
//   o_rsp   | out | quotient, divide_by_zero
//
// One transfer accepted per cycle while o_rsp is not stalled; stages: input
// register, 64 restoring-division stages of one bit each, rounding stage,
// output register. Each division stage holds one 65-bit subtract and compare.
// i_rst_n clears the valid bits only. A stall at o_rsp freezes the whole
// pipeline and drops i_req.ready in the same cycle.
// ----------------------------------------------------------------------------
module rounding_ceiling_divider (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rcd_in_if.sink   i_req,
    rcd_out_if.source o_rsp
);
    import rcd_pkg::*;

    function automatic t_stage div_step(input t_stage s);
        t_stage        o;
        logic [DW:0]   trial;
        logic [DW+1:0] diff;
        o     = s;
        trial = {s.rem, s.nq[DW-1]};
        diff  = {1'b0, trial} - {2'b00, s.div};
        if (!diff[DW+1]) begin
            o.rem = diff[DW-1:0];
        end else begin
            o.rem = trial[DW-1:0];
        end
        o.nq = {s.nq[DW-2:0], ~diff[DW+1]};
        return o;
    endfunction

    logic   adv;
    t_stage r_s  [0:DW];
    logic   r_sv [0:DW];
    t_stage n_s  [0:DW];
    t_fin   r_fin;
    t_fin   n_fin;
    logic   r_fv;
    logic   r_ov;
    logic [DW-1:0] r_q;
    logic          r_dz;

    assign adv         = !r_ov || o_rsp.ready;
    assign i_req.ready = adv;

    always_comb begin
        n_s[0].func   = i_req.func;
        n_s[0].zero_a = (i_req.dividend == '0);
        n_s[0].zero_b = (i_req.divisor == '0);
        n_s[0].div    = i_req.divisor;
        n_s[0].rem    = '0;
        n_s[0].nq     = i_req.func ? (i_req.dividend - DW'(1)) : i_req.dividend;
        for (int k = 0; k < DW; k++) begin
            n_s[k+1] = div_step(r_s[k]);
        end
        n_fin.zero_a = r_s[DW].zero_a;
        n_fin.zero_b = r_s[DW].zero_b;
        n_fin.q      = r_s[DW].nq;
        // round: r >= ceil(b/2) is the same as 2r >= b
        n_fin.inc    = r_s[DW].func || ({r_s[DW].rem, 1'b0} >= {1'b0, r_s[DW].div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= DW; k++) begin
                r_sv[k] <= 1'b0;
            end
            r_fv <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_sv[0] <= i_req.valid;
            for (int k = 0; k < DW; k++) begin
                r_sv[k+1] <= r_sv[k];
            end
            r_fv <= r_sv[DW];
            r_ov <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k <= DW; k++) begin
                r_s[k] <= n_s[k];
            end
            r_fin <= n_fin;
            if (r_fin.zero_a) begin
                r_q <= '0;
            end else if (r_fin.zero_b) begin
                r_q <= '1;
            end else begin
                r_q <= r_fin.q + DW'(r_fin.inc);
            end
            r_dz <= !r_fin.zero_a && r_fin.zero_b;
        end
    end

    assign o_rsp.valid          = r_ov;
    assign o_rsp.quotient       = r_q;
    assign o_rsp.divide_by_zero = r_dz;

endmodule

// File: rtl/rcd_checker.sv
// ----------------------------------------------------------------------------
// rcd_port_checks
// Port-level checks on the rounding / ceiling divider, bound to the top level.
// ----------------------------------------------------------------------------
module rcd_port_checks (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic [rcd_pkg::DW-1:0] i_rsp_quotient,
    input logic                  i_rsp_dz
);
    import rcd_pkg::*;

    a_dz_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_dz |-> (i_rsp_quotient == {DW{1'b1}}))
        else $error("divide by zero without all-ones quotient");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |-> !i_req_ready)
        else $error("input ready while output stalled");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_rsp_quotient) && $stable(i_rsp_dz))
        else $error("stalled result changed");

endmodule

bind rounding_ceiling_divider rcd_port_checks u_rcd_port_checks (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_quotient (o_rsp.quotient),
    .i_rsp_dz       (o_rsp.divide_by_zero)
);
